FILE: src/l3d_pkg.sv
// Shared types, constants and helpers for the 3D LUT color map unit.
// Used by every module of the block; depends on nothing.
package l3d_pkg;

    // Fixed field widths of the item formats.
    localparam int ENTRY_FRAC_BITS = 16;
    localparam int ENTRY_W         = ENTRY_FRAC_BITS + 1;
    localparam int IDX_W           = 13;
    localparam int SIZE_W          = 5;
    localparam int LUT_DIM_DEF     = 17;
    localparam int CORNERS         = 8;

    localparam logic [SIZE_W-1:0] LUT_SIZE_RESET = SIZE_W'(17);

    // Command codes.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [IDX_W-1:0]   entry_index;
        logic [ENTRY_W-1:0] entry_red;
        logic [ENTRY_W-1:0] entry_green;
        logic [ENTRY_W-1:0] entry_blue;
        logic [7:0]         pix_red;
        logic [7:0]         pix_green;
        logic [7:0]         pix_blue;
        logic               frame_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       last_out;
    } out_item_t;

    // One table entry: three channel values.
    typedef struct packed {
        logic [ENTRY_W-1:0] red;
        logic [ENTRY_W-1:0] green;
        logic [ENTRY_W-1:0] blue;
    } entry_t;

    // Per-pixel control that rides along with the corner addresses.
    typedef struct packed {
        logic       pixel;
        logic       last;
        logic [7:0] fr_r;
        logic [7:0] fr_g;
        logic [7:0] fr_b;
    } ctl_t;

    // Selects one channel of an entry: 0 red, 1 green, 2 blue.
    function automatic logic [ENTRY_W-1:0] chan_sel(entry_t e, int ch);
        logic [ENTRY_W-1:0] v;
        case (ch)
            0:       v = e.red;
            1:       v = e.green;
            default: v = e.blue;
        endcase
        return v;
    endfunction

endpackage

FILE: src/l3d_addr.sv
// Address pipeline of the 3D LUT unit: scales the pixel, finds the lattice
// cell and forms the eight corner addresses and the table write. Depends on l3d_pkg.
module l3d_addr #(
    parameter int LUT_DIM = l3d_pkg::LUT_DIM_DEF,
    parameter int SW      = $clog2(LUT_DIM + 1),
    parameter int AW      = $clog2(LUT_DIM * LUT_DIM * LUT_DIM)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 item_valid,
    input  l3d_pkg::in_item_t    item,
    input  logic [SW-1:0]        eff_size,
    output logic                 s3_valid,
    output l3d_pkg::ctl_t        s3_ctl,
    output logic [AW-1:0]        s3_addr [l3d_pkg::CORNERS],
    output logic                 s3_wr,
    output logic [AW-1:0]        s3_wr_addr,
    output l3d_pkg::entry_t      s3_wr_data
);
    import l3d_pkg::*;

    localparam int DEPTH   = LUT_DIM * LUT_DIM * LUT_DIM;
    localparam int COORD_W = (LUT_DIM > 2) ? $clog2(LUT_DIM) : 1;
    localparam int BGW     = $clog2(LUT_DIM * LUT_DIM);
    localparam int PW      = 8 + SW;

    logic                s1_valid_reg;
    in_item_t            s1_item_reg;
    logic [PW-1:0]       s1_pos_reg [3];

    logic                s2_valid_reg;
    in_item_t            s2_item_reg;
    logic [7:0]          s2_fr_reg [3];
    logic [COORD_W-1:0]  s2_r_reg [2];
    logic [BGW-1:0]      s2_bg_reg [4];

    logic                s3_valid_reg;
    ctl_t                s3_ctl_reg;
    logic [AW-1:0]       s3_addr_reg [CORNERS];
    logic                s3_wr_reg;
    logic [AW-1:0]       s3_wr_addr_reg;
    entry_t              s3_wr_data_reg;

    logic [SW-1:0]       size_m1;
    logic [7:0]          pix [3];
    logic [COORD_W-1:0]  lo [3];
    logic [COORD_W-1:0]  hi [3];

    // Stage 1: position on each axis is pixel times (size - 1).
    assign size_m1 = eff_size - SW'(1);
    assign pix[0]  = item.pix_red;
    assign pix[1]  = item.pix_green;
    assign pix[2]  = item.pix_blue;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_item_reg <= item;
            for (int a = 0; a < 3; a++)
            begin
                s1_pos_reg[a] <= PW'(pix[a]) * PW'(size_m1);
            end
        end
    end

    // Stage 2: lower and upper corners, and the blue/green part of the index.
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            lo[a] = COORD_W'(s1_pos_reg[a] >> 8);
            hi[a] = (s1_pos_reg[a][7:0] != 8'd0) ? lo[a] + COORD_W'(1) : lo[a];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_item_reg <= s1_item_reg;
            for (int a = 0; a < 3; a++)
            begin
                s2_fr_reg[a] <= s1_pos_reg[a][7:0];
            end
            s2_r_reg[0] <= lo[0];
            s2_r_reg[1] <= hi[0];
            for (int k = 0; k < 2; k++)
            begin
                for (int j = 0; j < 2; j++)
                begin
                    s2_bg_reg[k*2+j] <= BGW'(BGW'(k != 0 ? hi[2] : lo[2]) * BGW'(eff_size))
                                        + BGW'(j != 0 ? hi[1] : lo[1]);
                end
            end
        end
    end

    // Stage 3: full corner addresses, and the decoded table write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s3_wr_reg    <= 1'b0;
        end
        else if (adv)
        begin
            s3_valid_reg <= s2_valid_reg;
            s3_wr_reg    <= s2_valid_reg && (s2_item_reg.cmd == CMD_WRITE)
                            && (32'(s2_item_reg.entry_index) < 32'(DEPTH));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_ctl_reg.pixel <= (s2_item_reg.cmd == CMD_PIXEL);
            s3_ctl_reg.last  <= s2_item_reg.frame_end;
            s3_ctl_reg.fr_r  <= s2_fr_reg[0];
            s3_ctl_reg.fr_g  <= s2_fr_reg[1];
            s3_ctl_reg.fr_b  <= s2_fr_reg[2];
            for (int c = 0; c < CORNERS; c++)
            begin
                s3_addr_reg[c] <= AW'(AW'(s2_bg_reg[c/2]) * AW'(eff_size))
                                  + AW'(s2_r_reg[c%2]);
            end
            s3_wr_addr_reg       <= AW'(s2_item_reg.entry_index);
            s3_wr_data_reg.red   <= s2_item_reg.entry_red;
            s3_wr_data_reg.green <= s2_item_reg.entry_green;
            s3_wr_data_reg.blue  <= s2_item_reg.entry_blue;
        end
    end

    assign s3_valid   = s3_valid_reg;
    assign s3_ctl     = s3_ctl_reg;
    assign s3_addr    = s3_addr_reg;
    assign s3_wr      = s3_wr_reg;
    assign s3_wr_addr = s3_wr_addr_reg;
    assign s3_wr_data = s3_wr_data_reg;

endmodule

FILE: src/l3d_mem.sv
// Lattice store of the 3D LUT unit: four copies of the table, each with two
// read ports, so all eight corners are read together. Depends on l3d_pkg.
module l3d_mem #(
    parameter int LUT_DIM = l3d_pkg::LUT_DIM_DEF,
    parameter int AW      = $clog2(LUT_DIM * LUT_DIM * LUT_DIM)
) (
    input  logic             clk,
    input  logic             adv,
    input  logic             wr,
    input  logic [AW-1:0]    wr_addr,
    input  l3d_pkg::entry_t  wr_data,
    input  logic [AW-1:0]    rd_addr [l3d_pkg::CORNERS],
    output l3d_pkg::entry_t  rd_data [l3d_pkg::CORNERS]
);
    import l3d_pkg::*;

    localparam int DEPTH = LUT_DIM * LUT_DIM * LUT_DIM;

    // Every copy takes every write; each copy serves two corners.
    for (genvar q = 0; q < CORNERS / 2; q++)
    begin : g_copy
        entry_t mem [DEPTH];
        entry_t rd0_reg;
        entry_t rd1_reg;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (wr)
                begin
                    mem[wr_addr] <= wr_data;
                end
                rd0_reg <= mem[rd_addr[2*q]];
                rd1_reg <= mem[rd_addr[2*q+1]];
            end
        end

        assign rd_data[2*q]   = rd0_reg;
        assign rd_data[2*q+1] = rd1_reg;
    end

endmodule

FILE: src/l3d_interp.sv
// Interpolation pipeline of the 3D LUT unit: x, y and z blends for three
// channels, then floor and saturate into the output register. Depends on l3d_pkg.
module l3d_interp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                dst_stall,
    output logic                adv,
    input  logic                s3_valid,
    input  l3d_pkg::ctl_t       s3_ctl,
    input  l3d_pkg::entry_t     corner [l3d_pkg::CORNERS],
    output logic                dst_valid,
    output l3d_pkg::out_item_t  dst_item
);
    import l3d_pkg::*;

    localparam int XW = ENTRY_W + 8;
    localparam int YW = ENTRY_W + 16;
    localparam int ZW = ENTRY_W + 24;

    logic       s4_valid_reg;
    ctl_t       s4_ctl_reg;
    logic       s5_valid_reg;
    ctl_t       s5_ctl_reg;
    logic [XW-1:0] x_reg [3][4];
    logic       s6_valid_reg;
    ctl_t       s6_ctl_reg;
    logic [YW-1:0] y_reg [3][2];
    logic       s7_valid_reg;
    logic       s7_last_reg;
    logic [ZW-1:0] z_reg [3];
    logic       dst_valid_reg;
    out_item_t  dst_item_reg;

    logic [7:0] sat [3];
    logic [8:0] top_bits [3];

    // The whole pipeline moves unless a finished pixel is held at the output.
    assign adv = !dst_valid_reg || !dst_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            s7_valid_reg  <= 1'b0;
            dst_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s4_valid_reg  <= s3_valid && s3_ctl.pixel;
            s5_valid_reg  <= s4_valid_reg;
            s6_valid_reg  <= s5_valid_reg;
            s7_valid_reg  <= s6_valid_reg;
            dst_valid_reg <= s7_valid_reg;
        end
    end

    // Blend stages: each computes a*(256-f) + b*f exactly.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_ctl_reg <= s3_ctl;
            s5_ctl_reg <= s4_ctl_reg;
            s6_ctl_reg <= s5_ctl_reg;
            s7_last_reg <= s6_ctl_reg.last;
            for (int ch = 0; ch < 3; ch++)
            begin
                for (int p = 0; p < 4; p++)
                begin
                    x_reg[ch][p] <=
                        XW'(chan_sel(corner[2*p], ch)) * XW'(9'd256 - {1'b0, s4_ctl_reg.fr_r})
                        + XW'(chan_sel(corner[2*p+1], ch)) * XW'(s4_ctl_reg.fr_r);
                end
                for (int k = 0; k < 2; k++)
                begin
                    y_reg[ch][k] <=
                        YW'(x_reg[ch][2*k]) * YW'(9'd256 - {1'b0, s5_ctl_reg.fr_g})
                        + YW'(x_reg[ch][2*k+1]) * YW'(s5_ctl_reg.fr_g);
                end
                z_reg[ch] <= ZW'(y_reg[ch][0]) * ZW'(9'd256 - {1'b0, s6_ctl_reg.fr_b})
                             + ZW'(y_reg[ch][1]) * ZW'(s6_ctl_reg.fr_b);
            end
        end
    end

    // Keep eight fraction bits of the result and saturate to a byte.
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            top_bits[ch] = z_reg[ch][ZW-1:ENTRY_FRAC_BITS+16];
            sat[ch]      = top_bits[ch][8] ? 8'hFF : top_bits[ch][7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dst_item_reg.out_red   <= sat[0];
            dst_item_reg.out_green <= sat[1];
            dst_item_reg.out_blue  <= sat[2];
            dst_item_reg.last_out  <= s7_last_reg;
        end
    end

    assign dst_valid = dst_valid_reg;
    assign dst_item  = dst_item_reg;

    // A stalled pipeline keeps the valid bits of stages 5 to 7.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(s5_valid_reg) && $stable(s6_valid_reg) && $stable(s7_valid_reg))
        else $error("pipeline valid changed while stalled");

    // A new result appears only after the pipeline advanced.
    a_rise_adv: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dst_valid_reg) |-> $past(adv))
        else $error("result appeared without advance");

    // A result held at the output keeps its payload.
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid_reg && !adv |=> dst_valid_reg && $stable(dst_item_reg))
        else $error("held result changed");

endmodule

FILE: src/lut3d_trilinear_color_map_unit.sv
// Top level of the 3D LUT color map unit with trilinear interpolation.
// Depends on l3d_pkg, l3d_addr, l3d_mem and l3d_interp.
//
// Maps one 8-bit RGB pixel per clock through a lattice of up to LUT_DIM^3
// entries. Table writes and pixels share the input channel and are taken one
// per clock in order; a write lands in the table at the same pipeline stage
// where pixels read it, so order is always kept. A pixel's result passes
// after acceptance through three address stages, one table read stage
// (four table copies, two read ports each, give all eight corners at once),
// three blend stages and the output register. Writes give no result. The
// whole pipeline stalls only while a result waits at the output; the table
// contents are undefined until written and need no clearing after reset.
module lut3d_trilinear_color_map_unit #(
    parameter int LUT_DIM = l3d_pkg::LUT_DIM_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       src_valid,
    output logic                       src_stall,
    input  l3d_pkg::in_item_t          src_item,
    output logic                       dst_valid,
    input  logic                       dst_stall,
    output l3d_pkg::out_item_t         dst_item,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [l3d_pkg::SIZE_W-1:0] cfg_data
);
    import l3d_pkg::*;

    localparam int SW = $clog2(LUT_DIM + 1);
    localparam int AW = $clog2(LUT_DIM * LUT_DIM * LUT_DIM);

    logic [SIZE_W-1:0] lut_size_reg;
    logic [SW-1:0]     eff_size;
    logic              adv;
    logic              s3_valid;
    ctl_t              s3_ctl;
    logic [AW-1:0]     s3_addr [CORNERS];
    logic              s3_wr;
    logic [AW-1:0]     s3_wr_addr;
    entry_t            s3_wr_data;
    entry_t            corner [CORNERS];

    // Size register, always ready for a write transaction.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lut_size_reg <= LUT_SIZE_RESET;
        end
        else if (cfg_valid)
        begin
            lut_size_reg <= cfg_data;
        end
    end

    // Clamp the size to 1..LUT_DIM.
    always_comb
    begin
        if (lut_size_reg == '0)
        begin
            eff_size = SW'(1);
        end
        else if (32'(lut_size_reg) > 32'(LUT_DIM))
        begin
            eff_size = SW'(LUT_DIM);
        end
        else
        begin
            eff_size = SW'(lut_size_reg);
        end
    end

    assign src_stall = !adv;

    l3d_addr #(.LUT_DIM(LUT_DIM), .SW(SW), .AW(AW)) u_addr (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .item_valid (src_valid),
        .item       (src_item),
        .eff_size   (eff_size),
        .s3_valid   (s3_valid),
        .s3_ctl     (s3_ctl),
        .s3_addr    (s3_addr),
        .s3_wr      (s3_wr),
        .s3_wr_addr (s3_wr_addr),
        .s3_wr_data (s3_wr_data)
    );

    l3d_mem #(.LUT_DIM(LUT_DIM), .AW(AW)) u_mem (
        .clk     (clk),
        .adv     (adv),
        .wr      (s3_wr),
        .wr_addr (s3_wr_addr),
        .wr_data (s3_wr_data),
        .rd_addr (s3_addr),
        .rd_data (corner)
    );

    l3d_interp u_interp (
        .clk       (clk),
        .rst_n     (rst_n),
        .dst_stall (dst_stall),
        .adv       (adv),
        .s3_valid  (s3_valid),
        .s3_ctl    (s3_ctl),
        .corner    (corner),
        .dst_valid (dst_valid),
        .dst_item  (dst_item)
    );

    // Input backpressure comes only from a held result.
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        src_stall |-> dst_valid && dst_stall)
        else $error("input stalled without output backpressure");

endmodule
